// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the task queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/wtq_pkg.sv =====
// Package with types, codes and constants of the wake-time ordered task queue.
package wtq_pkg;

   localparam int TaskWidth  = 8;
   localparam int DelayWidth = 40;
   localparam int NowWidth   = 32;
   localparam int FracBits   = 8;
   localparam int WakeWidth  = 41;
   localparam int EntryWidth = WakeWidth + TaskWidth;

   // Default queue depth and the number of task ids that may be queued.
   localparam int DefaultQueueDepth = 16;
   localparam int MaxTasks          = 256;

   // Half a sample in the fractional time format.
   localparam logic [FracBits-1:0] HalfSample = 8'd128;

   // Request codes.
   localparam logic [1:0] REQ_SCHEDULE = 2'd0;
   localparam logic [1:0] REQ_TAKE     = 2'd1;
   localparam logic [1:0] REQ_REMOVE   = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOT_QUED = 2'd2;
   localparam logic [1:0] STATUS_NOT_DUE  = 2'd3;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [TaskWidth-1:0]  task_id;
      logic [DelayWidth-1:0] delay;
      logic [NowWidth-1:0]   now;
      logic                  none_alive;
   } req_item_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [TaskWidth-1:0] ready_id;
      logic                 stop_request;
      logic                 current_valid;
      logic [TaskWidth-1:0] current_id;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_HEAD_RD,
      ST_HEAD_CMP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_INS_WR,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/wake_time_ordered_task_queue.sv =====
// Top level of the wake-time ordered task queue with its sequencer.
//
// Usage: the block keeps up to QUEUE_DEPTH task ids sorted by absolute wake
// time (whole samples with 8 fractional bits). Items arrive on the req_
// channel (valid/stall) and each one gives exactly one item on the rsp_
// channel. A schedule item places a task at now plus delay after all entries
// with an equal time, a take item pops the head when it is due by now plus
// half a sample, and a remove item unlinks a task. The user must write the
// loop_forever bit on the csr_ port only while the block is idle; the block
// itself does not enforce it.
// One entry RAM and one 41-bit compare unit do all the work, and each entry
// visited passes through a read state and a compare or write state. The work
// of an item grows with the queue fill and the number of entries shifted; an
// item on an empty queue skips the scan.
// req_stall is high while an item is in work; the next one is accepted in the
// cycle after its result is loaded at the earliest.
// Reset empties the queue, clears the current-task marker and loop_forever.
// A stalled result waits in the output register, and the next item may be
// accepted meanwhile; its result waits until the register is free.
module wake_time_ordered_task_queue #(
   parameter int QUEUE_DEPTH = wtq_pkg::DefaultQueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wtq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wtq_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

`include "assert_macros.svh"

   localparam int IdxWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(QUEUE_DEPTH);
   localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);

   // Control registers.
   wtq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [wtq_pkg::TaskWidth-1:0] cur_id_ff, cur_id_in;
   logic                loop_ff;

   // Work registers of the item in progress.
   wtq_pkg::req_item_type req_ff, req_in;
   wtq_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic [wtq_pkg::WakeWidth-1:0] cmp_ref_ff, cmp_ref_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic [CntWidth-1:0] le_ff, le_in;
   logic                found_ff, found_in;
   logic [IdxWidth-1:0] pos_ff, pos_in;
   logic [IdxWidth-1:0] at_ff, at_in;
   logic [IdxWidth-1:0] dst_ff, dst_in;
   logic [IdxWidth-1:0] lim_ff, lim_in;
   logic                down_ff, down_in;
   logic                ins_ff, ins_in;
   logic [1:0]          status_ff, status_in;
   logic [wtq_pkg::TaskWidth-1:0] ready_ff, ready_in;
   logic                stop_ff, stop_in;

   // RAM port signals.
   logic                ram_we;
   logic [IdxWidth-1:0] ram_waddr;
   logic [wtq_pkg::EntryWidth-1:0] ram_wdata;
   logic [IdxWidth-1:0] ram_raddr;
   logic [wtq_pkg::EntryWidth-1:0] ram_rdata;
   logic [wtq_pkg::WakeWidth-1:0]  rd_wake;
   logic [wtq_pkg::TaskWidth-1:0]  rd_task;

   wtq_ram #(
      .WIDTH (wtq_pkg::EntryWidth),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_wake = ram_rdata[wtq_pkg::EntryWidth-1:wtq_pkg::TaskWidth];
   assign rd_task = ram_rdata[wtq_pkg::TaskWidth-1:0];

   // The shared compare unit: entry wake time against the reference time.
   logic cmp_le;
   assign cmp_le = (rd_wake <= cmp_ref_ff);

   // Request decode helpers on the incoming item.
   logic accept;
   logic id_in_range;
   logic [wtq_pkg::WakeWidth-1:0] new_wake;
   logic [wtq_pkg::WakeWidth-1:0] due_time;

   assign req_stall = (state_ff != wtq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign id_in_range = (32'(req_item.task_id) < 32'(wtq_pkg::MaxTasks));
   assign new_wake = {1'b0, req_item.now, {wtq_pkg::FracBits{1'b0}}}
                   + {1'b0, req_item.delay};
   assign due_time = {1'b0, req_item.now, wtq_pkg::HalfSample};

   // Scan results including the entry in the compare stage.
   logic                hit;
   logic                found_now;
   logic [IdxWidth-1:0] pos_now;
   logic [CntWidth-1:0] le_next;
   logic [CntWidth-1:0] idx_next_wide;
   logic [IdxWidth-1:0] at_now;
   logic                move_more;

   assign hit           = (rd_task == req_ff.task_id);
   assign found_now     = found_ff || hit;
   assign pos_now       = found_ff ? pos_ff : idx_ff;
   assign le_next       = le_ff + CntWidth'(!hit && cmp_le);
   assign idx_next_wide = CntWidth'(idx_ff) + CntOne;
   assign at_now        = le_next[IdxWidth-1:0];
   assign move_more     = down_ff ? (dst_ff < lim_ff) : (dst_ff > lim_ff);

   // Sequencer: next state, work registers and RAM control.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cnt_in       = cnt_ff;
      cur_valid_in = cur_valid_ff;
      cur_id_in    = cur_id_ff;
      req_in       = req_ff;
      rsp_item_in  = rsp_item_ff;
      cmp_ref_in   = cmp_ref_ff;
      idx_in       = idx_ff;
      le_in        = le_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      at_in        = at_ff;
      dst_in       = dst_ff;
      lim_in       = lim_ff;
      down_in      = down_ff;
      ins_in       = ins_ff;
      status_in    = status_ff;
      ready_in     = ready_ff;
      stop_in      = stop_ff;
      ram_we       = 1'b0;
      ram_waddr    = dst_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = idx_ff;

      // The output register frees when its item is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wtq_pkg::ST_IDLE: begin
            if (accept) begin
               req_in    = req_item;
               idx_in    = '0;
               le_in     = '0;
               found_in  = 1'b0;
               pos_in    = '0;
               status_in = wtq_pkg::STATUS_OK;
               ready_in  = '0;
               stop_in   = 1'b0;
               state_in  = wtq_pkg::ST_DONE;
               unique case (req_item.req_type)
                  wtq_pkg::REQ_SCHEDULE: begin
                     cmp_ref_in = new_wake;
                     if (!id_in_range) begin
                        status_in = wtq_pkg::STATUS_NOT_QUED;
                     end else if (cnt_ff == '0) begin
                        at_in    = '0;
                        state_in = wtq_pkg::ST_INS_WR;
                     end else begin
                        state_in = wtq_pkg::ST_SCAN_RD;
                     end
                  end
                  wtq_pkg::REQ_TAKE: begin
                     cmp_ref_in = due_time;
                     if (cnt_ff == '0) begin
                        status_in = wtq_pkg::STATUS_NOT_DUE;
                        stop_in   = req_item.none_alive && !loop_ff;
                     end else begin
                        state_in = wtq_pkg::ST_HEAD_RD;
                     end
                  end
                  wtq_pkg::REQ_REMOVE: begin
                     // The marker survives only if it names this task.
                     if (!(cur_valid_ff && cur_id_ff == req_item.task_id)) begin
                        cur_valid_in = 1'b0;
                        cur_id_in    = '0;
                     end
                     if (!id_in_range || cnt_ff == '0) begin
                        status_in = wtq_pkg::STATUS_NOT_QUED;
                     end else begin
                        state_in = wtq_pkg::ST_SCAN_RD;
                     end
                  end
                  default: begin
                     status_in = wtq_pkg::STATUS_OK;
                  end
               endcase
            end
         end

         wtq_pkg::ST_SCAN_RD: begin
            ram_raddr = idx_ff;
            state_in  = wtq_pkg::ST_SCAN_CMP;
         end

         wtq_pkg::ST_SCAN_CMP: begin
            // Look for the id and count earlier entries not after the new time.
            found_in = found_now;
            pos_in   = pos_now;
            le_in    = le_next;
            idx_in   = idx_ff + IdxWidth'(1);
            if (idx_next_wide < cnt_ff) begin
               state_in = wtq_pkg::ST_SCAN_RD;
            end else if (req_ff.req_type == wtq_pkg::REQ_SCHEDULE) begin
               if (!found_now && cnt_ff == CntFull) begin
                  status_in = wtq_pkg::STATUS_FULL;
                  state_in  = wtq_pkg::ST_DONE;
               end else begin
                  at_in  = at_now;
                  ins_in = 1'b1;
                  lim_in = at_now;
                  if (found_now) begin
                     dst_in  = pos_now;
                     down_in = (at_now >= pos_now);
                  end else begin
                     dst_in  = cnt_ff[IdxWidth-1:0];
                     down_in = 1'b0;
                  end
                  state_in = wtq_pkg::ST_MOVE_RD;
               end
            end else begin
               if (!found_now) begin
                  status_in = wtq_pkg::STATUS_NOT_QUED;
                  state_in  = wtq_pkg::ST_DONE;
               end else begin
                  ins_in   = 1'b0;
                  down_in  = 1'b1;
                  dst_in   = pos_now;
                  lim_in   = IdxWidth'(cnt_ff - CntOne);
                  state_in = wtq_pkg::ST_MOVE_RD;
               end
            end
         end

         wtq_pkg::ST_HEAD_RD: begin
            ram_raddr = '0;
            state_in  = wtq_pkg::ST_HEAD_CMP;
         end

         wtq_pkg::ST_HEAD_CMP: begin
            // Pop the head when it is due and close the gap behind it.
            if (cmp_le) begin
               ready_in     = rd_task;
               cur_valid_in = 1'b1;
               cur_id_in    = rd_task;
               ins_in       = 1'b0;
               down_in      = 1'b1;
               dst_in       = '0;
               lim_in       = IdxWidth'(cnt_ff - CntOne);
               state_in     = wtq_pkg::ST_MOVE_RD;
            end else begin
               status_in = wtq_pkg::STATUS_NOT_DUE;
               state_in  = wtq_pkg::ST_DONE;
            end
         end

         wtq_pkg::ST_MOVE_RD: begin
            // Fetch the neighbor that moves into the current slot.
            ram_raddr = down_ff ? (dst_ff + IdxWidth'(1)) : (dst_ff - IdxWidth'(1));
            if (move_more) begin
               state_in = wtq_pkg::ST_MOVE_WR;
            end else if (ins_ff) begin
               state_in = wtq_pkg::ST_INS_WR;
            end else begin
               cnt_in   = cnt_ff - CntOne;
               state_in = wtq_pkg::ST_DONE;
            end
         end

         wtq_pkg::ST_MOVE_WR: begin
            ram_we    = 1'b1;
            ram_waddr = dst_ff;
            ram_wdata = ram_rdata;
            dst_in    = down_ff ? (dst_ff + IdxWidth'(1)) : (dst_ff - IdxWidth'(1));
            state_in  = wtq_pkg::ST_MOVE_RD;
         end

         wtq_pkg::ST_INS_WR: begin
            // Store the new entry; a rescheduled task keeps the fill unchanged.
            ram_we    = 1'b1;
            ram_waddr = at_ff;
            ram_wdata = {cmp_ref_ff, req_ff.task_id};
            if (!found_ff) begin
               cnt_in = cnt_ff + CntOne;
            end
            if (cur_valid_ff && cur_id_ff == req_ff.task_id) begin
               cur_valid_in = 1'b0;
               cur_id_in    = '0;
            end
            state_in = wtq_pkg::ST_DONE;
         end

         wtq_pkg::ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.status         = status_ff;
               rsp_item_in.ready_id       = ready_ff;
               rsp_item_in.stop_request   = stop_ff;
               rsp_item_in.current_valid  = cur_valid_ff;
               rsp_item_in.current_id     = cur_id_ff;
               state_in                   = wtq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wtq_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wtq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         cur_valid_ff <= 1'b0;
         cur_id_ff    <= '0;
         loop_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         cur_valid_ff <= cur_valid_in;
         cur_id_ff    <= cur_id_in;
         if (csr_wr_en) begin
            loop_ff <= csr_wr_data;
         end
      end
   end

   // Work and payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_item_ff <= rsp_item_in;
      cmp_ref_ff  <= cmp_ref_in;
      idx_ff      <= idx_in;
      le_ff       <= le_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      at_ff       <= at_in;
      dst_ff      <= dst_in;
      lim_ff      <= lim_in;
      down_ff     <= down_in;
      ins_ff      <= ins_in;
      status_ff   <= status_in;
      ready_ff    <= ready_in;
      stop_ff     <= stop_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Assertions on the sequencer and queue bookkeeping.
   `ASSERT_CLK(a_fill_bound, cnt_ff <= CntFull, "queue fill above depth")
   `ASSERT_CLK(a_accept_busy, accept |=> state_ff != wtq_pkg::ST_IDLE,
               "accepted item did not start work")
   `ASSERT_CLK(a_marker_clear, !cur_valid_ff |-> cur_id_ff == '0,
               "invalid marker holds a nonzero id")
   `ASSERT_NEVER(a_insert_overflow,
                 state_ff == wtq_pkg::ST_INS_WR && !found_ff && cnt_ff == CntFull,
                 "insert into a full queue")

endmodule

// ===== rtl/wtq_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
module wtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the wake-time ordered task queue.
module testbench;

   // The request code that the block does not define; it must leave all state alone.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int SettleCycles = 100;
   localparam int PrintLimit   = 40;

   // Field widths used in casts.
   localparam int IdWidth   = wtq_pkg::TaskWidth;
   localparam int DelayBits = wtq_pkg::DelayWidth;
   localparam int WakeBits  = wtq_pkg::WakeWidth;

   // Tracks the sorted queue and the current-task marker, and checks each result item.
   class wake_order_checker;
      logic [wtq_pkg::WakeWidth-1:0] wake_at [wtq_pkg::DefaultQueueDepth];
      logic [wtq_pkg::TaskWidth-1:0] task_at [wtq_pkg::DefaultQueueDepth];
      int                            fill;
      bit                            marker_valid;
      logic [wtq_pkg::TaskWidth-1:0] marker_id;
      bit                            loop_forever;
      wtq_pkg::rsp_item_type         pending_answers [$];
      int                            mismatches;
      int                            n_checked;
      int n_sched, n_full, n_take, n_pop, n_stop, n_remove, n_hit, n_unused;

      function new();
         fill         = 0;
         marker_valid = 1'b0;
         marker_id    = '0;
         loop_forever = 1'b0;
         mismatches   = 0;
         n_checked    = 0;
         n_sched      = 0;
         n_full       = 0;
         n_take       = 0;
         n_pop        = 0;
         n_stop       = 0;
         n_remove     = 0;
         n_hit        = 0;
         n_unused     = 0;
      endfunction

      function void set_loop_forever(bit value);
         loop_forever = value;
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction

      function int find(logic [wtq_pkg::TaskWidth-1:0] id);
         for (int i = 0; i < fill; i++) begin
            if (task_at[i] == id) begin
               return i;
            end
         end
         return -1;
      endfunction

      // Closes the gap left by the entry at pos.
      function void unlink(int pos);
         for (int i = pos; i + 1 < fill; i++) begin
            wake_at[i] = wake_at[i + 1];
            task_at[i] = task_at[i + 1];
         end
         fill--;
      endfunction

      // Applies one accepted request item and stores the result item it must give.
      function void apply_request(wtq_pkg::req_item_type r);
         wtq_pkg::rsp_item_type         e;
         logic [wtq_pkg::WakeWidth-1:0] wake;
         logic [wtq_pkg::WakeWidth-1:0] due_limit;
         int                            pos;
         int                            at;
         e = '0;
         case (r.req_type)
            wtq_pkg::REQ_SCHEDULE: begin
               n_sched++;
               wake = {1'b0, r.now, {wtq_pkg::FracBits{1'b0}}} + {1'b0, r.delay};
               pos  = find(r.task_id);
               if (pos < 0 && fill >= wtq_pkg::DefaultQueueDepth) begin
                  e.status = wtq_pkg::STATUS_FULL;
                  n_full++;
               end else begin
                  // A task that is already queued loses its old place first.
                  if (pos >= 0) begin
                     unlink(pos);
                  end
                  at = 0;
                  while (at < fill && wake_at[at] <= wake) begin
                     at++;
                  end
                  for (int i = fill; i > at; i--) begin
                     wake_at[i] = wake_at[i - 1];
                     task_at[i] = task_at[i - 1];
                  end
                  wake_at[at] = wake;
                  task_at[at] = r.task_id;
                  fill++;
                  if (marker_valid && marker_id == r.task_id) begin
                     marker_valid = 1'b0;
                     marker_id    = '0;
                  end
                  e.status = wtq_pkg::STATUS_OK;
               end
            end
            wtq_pkg::REQ_TAKE: begin
               n_take++;
               due_limit = {1'b0, r.now, {wtq_pkg::FracBits{1'b0}}}
                         + WakeBits'(wtq_pkg::HalfSample);
               if (fill == 0) begin
                  e.status = wtq_pkg::STATUS_NOT_DUE;
                  if (r.none_alive && !loop_forever) begin
                     e.stop_request = 1'b1;
                     n_stop++;
                  end
               end else if (wake_at[0] <= due_limit) begin
                  e.status     = wtq_pkg::STATUS_OK;
                  e.ready_id   = task_at[0];
                  marker_valid = 1'b1;
                  marker_id    = task_at[0];
                  unlink(0);
                  n_pop++;
               end else begin
                  e.status = wtq_pkg::STATUS_NOT_DUE;
               end
            end
            wtq_pkg::REQ_REMOVE: begin
               n_remove++;
               // The marker survives only when it names the removed task.
               if (!(marker_valid && marker_id == r.task_id)) begin
                  marker_valid = 1'b0;
                  marker_id    = '0;
               end
               pos = find(r.task_id);
               if (pos < 0) begin
                  e.status = wtq_pkg::STATUS_NOT_QUED;
               end else begin
                  unlink(pos);
                  e.status = wtq_pkg::STATUS_OK;
                  n_hit++;
               end
            end
            default: begin
               n_unused++;
               e.status = wtq_pkg::STATUS_OK;
            end
         endcase
         e.current_valid = marker_valid;
         e.current_id    = marker_valid ? marker_id : '0;
         pending_answers.push_back(e);
      endfunction

      task report(string what, logic [wtq_pkg::TaskWidth-1:0] got,
                  logic [wtq_pkg::TaskWidth-1:0] want);
         mismatches++;
         if (mismatches <= PrintLimit) begin
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     n_checked, what, got, want);
         end
      endtask

      // Compares one accepted result item with the oldest expected one.
      task check_result(wtq_pkg::rsp_item_type got);
         wtq_pkg::rsp_item_type want;
         if (pending_answers.size() == 0) begin
            report("unexpected result item, status", IdWidth'(got.status), '0);
         end else begin
            want = pending_answers.pop_front();
            if (got.status !== want.status) begin
               report("status", IdWidth'(got.status), IdWidth'(want.status));
            end
            if (got.ready_id !== want.ready_id) begin
               report("ready_id", got.ready_id, want.ready_id);
            end
            if (got.stop_request !== want.stop_request) begin
               report("stop_request", IdWidth'(got.stop_request),
                      IdWidth'(want.stop_request));
            end
            if (got.current_valid !== want.current_valid) begin
               report("current_valid", IdWidth'(got.current_valid),
                      IdWidth'(want.current_valid));
            end
            if (got.current_id !== want.current_id) begin
               report("current_id", got.current_id, want.current_id);
            end
         end
         n_checked++;
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   wtq_pkg::req_item_type req_item    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   wtq_pkg::rsp_item_type rsp_item;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;

   wake_order_checker order_chk = new();

   bit          quiet        = 1'b0;
   bit          hold_request = 1'b0;
   logic [31:0] now_cursor   = '0;
   int          items_sent   = 0;

   wake_time_ordered_task_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Hard limit on the run time in case the block hangs.
   initial begin
      #8000000;
      $display("testbench: errors");
      $finish;
   end

   // Result side: checks accepted items and stalls in random bursts or one long hold.
   initial begin
      int free_left;
      int stall_left;
      int hold_left;
      free_left  = 0;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            order_chk.check_result(rsp_item);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            free_left = $urandom_range(0, 24);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic wtq_pkg::req_item_type make_item(logic [1:0] kind,
                                                       logic [wtq_pkg::TaskWidth-1:0] id,
                                                       logic [wtq_pkg::DelayWidth-1:0] dly,
                                                       logic [wtq_pkg::NowWidth-1:0] at_now,
                                                       logic alive_none);
      wtq_pkg::req_item_type it;
      it.req_type   = kind;
      it.task_id    = id;
      it.delay      = dly;
      it.now        = at_now;
      it.none_alive = alive_none;
      return it;
   endfunction

   // Offers one item, waits until it is taken, then maybe leaves a gap.
   task automatic send_item(input wtq_pkg::req_item_type it);
      int gap;
      req_valid <= 1'b1;
      req_item  <= it;
      do begin
         @(posedge clock);
      end while (req_stall);
      order_chk.apply_request(it);
      items_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every result item is back, lets the block settle, then writes the bit.
   task automatic settle_and_set_loop(input bit value);
      req_valid <= 1'b0;
      while (order_chk.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_chk.set_loop_forever(value);
   endtask

   // One phase of random traffic with a given request mix.
   task automatic run_phase(input bit loop_value, input int sched_pct, input int take_pct,
                            input bit long_hold, input bit no_idle, input int count);
      wtq_pkg::req_item_type          it;
      int                             sent;
      int                             roll;
      int                             pick;
      logic [1:0]                     kind;
      logic [wtq_pkg::TaskWidth-1:0]  id;
      logic [wtq_pkg::DelayWidth-1:0] dly;
      logic [wtq_pkg::NowWidth-1:0]   at_now;
      settle_and_set_loop(loop_value);
      quiet = no_idle;
      if (long_hold) begin
         hold_request = 1'b1;
      end
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < sched_pct) begin
            kind = wtq_pkg::REQ_SCHEDULE;
         end else if (roll < sched_pct + take_pct) begin
            kind = wtq_pkg::REQ_TAKE;
         end else if (roll < 97) begin
            kind = wtq_pkg::REQ_REMOVE;
         end else begin
            kind = REQ_UNUSED;
         end
         // A small id pool makes the queue fill, and re-schedules and removes hit.
         if ($urandom_range(0, 9) == 0) begin
            id = IdWidth'($urandom_range(0, 255));
         end else begin
            id = IdWidth'($urandom_range(0, 23));
         end
         now_cursor = now_cursor + $urandom_range(0, 3);
         at_now = ($urandom_range(0, 49) == 0) ? $urandom : now_cursor;
         // Coarse delays give many equal wake times; a few span the whole field.
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            dly = DelayBits'($urandom_range(0, 12) * 64);
         end else if (pick < 95) begin
            dly = DelayBits'($urandom_range(0, 4095));
         end else begin
            dly = {8'($urandom), 32'($urandom)};
         end
         it = make_item(kind, id, dly, at_now, 1'($urandom_range(0, 1)));
         send_item(it);
         if (kind != REQ_UNUSED) begin
            sent++;
         end
      end
   endtask

   // Main sequence: reset, directed cases, random phases, final drain.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      settle_and_set_loop(1'b0);

      // Empty queue: stop only when nothing is alive.
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'd0, 1'b1));
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_REMOVE, 8'd5, '0, 32'd0, 1'b0));
      // Field extremes, including a wake time near the top of the range.
      send_item(make_item(wtq_pkg::REQ_SCHEDULE, 8'd0, '0, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_SCHEDULE, 8'd255, '1, 32'd0, 1'b1));
      send_item(make_item(wtq_pkg::REQ_SCHEDULE, 8'd7, '1, 32'hFFFF_FFFF, 1'b0));
      // Equal time goes after the existing entry.
      send_item(make_item(wtq_pkg::REQ_SCHEDULE, 8'd3, '0, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'd0, 1'b0));
      // Scheduling the current task clears the marker; a wake of exactly half a sample is due.
      send_item(make_item(wtq_pkg::REQ_SCHEDULE, 8'd3, 40'd128, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_SCHEDULE, 8'd9, 40'd129, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'd0, 1'b0));
      // Re-scheduling a queued task moves it.
      send_item(make_item(wtq_pkg::REQ_SCHEDULE, 8'd9, '0, 32'd0, 1'b0));
      // Removing the current task keeps the marker; removing another clears it.
      send_item(make_item(wtq_pkg::REQ_REMOVE, 8'd3, '0, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_REMOVE, 8'd255, '0, 32'd0, 1'b0));
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'd0, 1'b0));
      send_item(make_item(REQ_UNUSED, 8'hFF, '1, 32'hFFFF_FFFF, 1'b1));
      send_item(make_item(wtq_pkg::REQ_TAKE, 8'd0, '0, 32'hFFFF_FFFF, 1'b1));

      run_phase(1'b1, 40, 37, 1'b0, 1'b0, 308);
      run_phase(1'b0, 65, 15, 1'b1, 1'b0, 308);
      run_phase(1'b1, 25, 55, 1'b0, 1'b0, 308);
      run_phase(1'b0, 40, 37, 1'b0, 1'b0, 308);
      run_phase(1'b1, 65, 15, 1'b0, 1'b0, 308);
      run_phase(1'b0, 40, 37, 1'b0, 1'b1, 310);

      req_valid <= 1'b0;
      while (order_chk.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d items: %0d schedules (%0d to a full queue), %0d removes (%0d hit)",
               items_sent, order_chk.n_sched, order_chk.n_full, order_chk.n_remove,
               order_chk.n_hit);
      $display("%0d takes (%0d popped, %0d stops), %0d unused codes, %0d results checked",
               order_chk.n_take, order_chk.n_pop, order_chk.n_stop, order_chk.n_unused,
               order_chk.n_checked);
      if (order_chk.mismatches == 0 && order_chk.pending() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
